### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and sizing helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int POS_W      = 5;
  localparam int K_W        = 4;
  localparam int TOT_W      = 32;
  localparam int FREE_W     = 17;
  localparam int FREE_LIMIT = 131071;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_BAD_ORDER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START_WALK,
    OP_NEXT_WORD,
    OP_NEXT_LEVEL,
    OP_TAKE,
    OP_SPLIT,
    OP_MERGE,
    OP_PLACE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic order_bad;
    logic out_of_pool;
    logic word_hit;
    logic last_word;
    logic at_max;
    logic at_order;
    logic buddy_free;
  } dp_stat_t;

  function automatic int blocks_at(int top, int maxo, int k);
    return top << (maxo - k);
  endfunction

  function automatic int words_at(int top, int maxo, int k);
    return (blocks_at(top, maxo, k) + WORD_BITS - 1) >> POS_W;
  endfunction

  // First bitmap word of order k; the orders are stacked from order zero up.
  function automatic int row_base(int top, int maxo, int k);
    int sum;
    int j;
    sum = 0;
    for (j = 0; j < 8; j++) begin
      if (j < k) sum = sum + words_at(top, maxo, j);
    end
    return sum;
  endfunction

  function automatic logic [POS_W-1:0] lowest_set(logic [WORD_BITS-1:0] w);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) r = POS_W'(i);
    end
    return r;
  endfunction

endpackage

### src/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end

endmodule

### src/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Free bitmaps, free byte count, pool base and the index arithmetic.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; #(
  parameter int MAX_ORDER     = 5,
  parameter int MIN_PAGE_LOG2 = 8,
  parameter int TOP_BLOCKS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_mode,
  input  logic [2:0]          in_order,
  input  logic [31:0]         in_address,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [1:0]          out_status,
  output logic [31:0]         out_block_address,
  output logic [FREE_W-1:0]   out_free_bytes
);

  localparam int DEPTH = row_base(TOP_BLOCKS, MAX_ORDER, MAX_ORDER + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int TOP_ROW = row_base(TOP_BLOCKS, MAX_ORDER, MAX_ORDER);
  localparam int WI_W  = $clog2(words_at(TOP_BLOCKS, MAX_ORDER, 0) + 1);
  localparam logic [31:0] TOP_MASK = 32'((64'd1 << TOP_BLOCKS) - 64'd1);
  localparam logic [TOT_W-1:0] POOL_BYTES =
    TOT_W'(TOP_BLOCKS) << (MAX_ORDER + MIN_PAGE_LOG2);
  localparam logic [K_W-1:0] K_MAX = K_W'(MAX_ORDER);
  localparam logic [4:0] MIN_SH = 5'(MIN_PAGE_LOG2);

  logic [31:0]      pool_base_r;
  logic [TOT_W-1:0] total_r;
  logic [DEPTH-1:0] valid_r;
  logic             mode_r;
  logic [2:0]       order_r;
  logic [31:0]      offset_r;
  logic [K_W-1:0]   k_r;
  logic [WI_W-1:0]  w_r;
  logic [31:0]      found_idx_r;
  logic [K_W-1:0]   found_k_r;
  logic [31:0]      blk_addr_r;
  logic             alloc_ok_r;
  logic             rvalid_r;
  logic             rtop_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_addr_r;
  logic [FREE_W-1:0] out_free_r;

  logic [AW-1:0]    ram_addr, srch_addr, free_addr, split_addr;
  logic             ram_we;
  logic [31:0]      ram_wdata, rdata, eff;
  logic [4:0]       sh_k, sh_o;
  logic [31:0]      idx_f, split_bit;
  logic [POS_W-1:0] pos_f, bud, pos_h;
  logic [TOT_W-1:0] size_k, size_o;
  logic [K_W-1:0]   order_k;
  int               base_k;

  assign order_k = {1'b0, order_r};
  assign base_k  = row_base(TOP_BLOCKS, MAX_ORDER, int'(k_r));
  assign sh_k    = 5'(k_r) + MIN_SH;
  assign sh_o    = 5'(order_r) + MIN_SH;
  assign size_k  = TOT_W'(1) << sh_k;
  assign size_o  = TOT_W'(1) << sh_o;

  assign idx_f      = offset_r >> sh_k;
  assign pos_f      = idx_f[POS_W-1:0];
  assign bud        = pos_f ^ POS_W'(1);
  // Splits walk the leftmost path below the found block: the right child at
  // each level becomes free.
  assign split_bit  = (found_idx_r << (found_k_r - k_r)) + 32'd1;

  assign srch_addr  = AW'(base_k + int'(w_r));
  assign free_addr  = AW'(base_k + int'(idx_f >> POS_W));
  assign split_addr = AW'(base_k + int'(split_bit >> POS_W));

  always_comb begin
    if (cmd.op == OP_SPLIT) ram_addr = split_addr;
    else if (mode_r)        ram_addr = free_addr;
    else                    ram_addr = srch_addr;
  end

  // A row never written still holds its reset contents.
  assign eff   = rvalid_r ? rdata : (rtop_r ? TOP_MASK : 32'd0);
  assign pos_h = lowest_set(eff);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = eff;
    case (cmd.op)
      OP_TAKE: begin
        ram_we    = 1'b1;
        ram_wdata = eff & ~(32'd1 << pos_h);
      end
      OP_SPLIT: begin
        ram_we    = 1'b1;
        ram_wdata = 32'd1 << split_bit[POS_W-1:0];
      end
      OP_MERGE: begin
        ram_we    = 1'b1;
        ram_wdata = eff & ~(32'd1 << bud);
      end
      OP_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = eff | (32'd1 << pos_f);
      end
      default: ;
    endcase
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_comb begin
    stat.is_free     = mode_r;
    stat.order_bad   = order_k > K_MAX;
    stat.out_of_pool = (offset_r >> sh_o) >= (32'(TOP_BLOCKS) << (K_MAX - order_k));
    stat.word_hit    = eff != 32'd0;
    stat.last_word   = int'(w_r) == words_at(TOP_BLOCKS, MAX_ORDER, int'(k_r)) - 1;
    stat.at_max      = k_r == K_MAX;
    stat.at_order    = k_r == order_k;
    stat.buddy_free  = eff[bud];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      total_r     <= POOL_BYTES;
      valid_r     <= '0;
    end else begin
      if (cfg_we) pool_base_r <= cfg_wdata;
      if (ram_we) valid_r[ram_addr] <= 1'b1;
      case (cmd.op)
        OP_TAKE:  total_r <= total_r - size_o;
        OP_MERGE: total_r <= total_r - size_k;
        OP_PLACE: if (!eff[pos_f]) total_r <= total_r + size_k;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rvalid_r <= valid_r[ram_addr];
    rtop_r   <= int'(ram_addr) == TOP_ROW;
    case (cmd.op)
      OP_LOAD: begin
        mode_r     <= in_mode;
        order_r    <= in_order;
        offset_r   <= in_address - pool_base_r;
        alloc_ok_r <= 1'b0;
      end
      OP_START_WALK: begin
        k_r <= order_k;
        w_r <= '0;
      end
      OP_NEXT_WORD: w_r <= w_r + WI_W'(1);
      OP_NEXT_LEVEL: begin
        k_r <= k_r + K_W'(1);
        w_r <= '0;
      end
      OP_TAKE: begin
        found_idx_r <= (32'(w_r) << POS_W) | 32'(pos_h);
        found_k_r   <= k_r;
        blk_addr_r  <= pool_base_r + (((32'(w_r) << POS_W) | 32'(pos_h)) << sh_k);
        alloc_ok_r  <= 1'b1;
        if (k_r != order_k) k_r <= k_r - K_W'(1);
      end
      OP_SPLIT: if (k_r != order_k) k_r <= k_r - K_W'(1);
      OP_MERGE: begin
        offset_r <= offset_r & ~(32'((33'd1 << (6'(sh_k) + 6'd1)) - 33'd1));
        k_r      <= k_r + K_W'(1);
      end
      OP_FINISH: begin
        out_status_r <= cmd.status;
        out_addr_r   <= alloc_ok_r ? blk_addr_r : 32'd0;
        out_free_r   <= (total_r > TOT_W'(FREE_LIMIT)) ? FREE_W'(FREE_LIMIT)
                                                       : total_r[FREE_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_free_bytes    = out_free_r;

endmodule

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for allocate search, split, and free merge.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    cmd.op        = OP_NONE;
    cmd.status    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_nxt = ST_OK;
        if (stat.order_bad) begin
          status_nxt = ST_BAD_ORDER;
          state_nxt  = S_DONE;
        end else if (!stat.is_free) begin
          cmd.op    = OP_START_WALK;
          state_nxt = S_SRCH_RD;
        end else if (stat.out_of_pool) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_START_WALK;
          state_nxt = S_FREE_RD;
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (stat.word_hit) begin
          cmd.op    = OP_TAKE;
          state_nxt = stat.at_order ? S_DONE : S_SPLIT;
        end else if (!stat.last_word) begin
          cmd.op    = OP_NEXT_WORD;
          state_nxt = S_SRCH_RD;
        end else if (stat.at_max) begin
          status_nxt = ST_NO_BLOCK;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = OP_NEXT_LEVEL;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = stat.at_order ? S_DONE : S_SPLIT;
      end
      S_FREE_RD: state_nxt = S_FREE_CHK;
      S_FREE_CHK: begin
        if (!stat.at_max && stat.buddy_free) begin
          cmd.op    = OP_MERGE;
          state_nxt = S_FREE_RD;
        end else begin
          cmd.op    = OP_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.op        = OP_FINISH;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid_r)
    else $error("busy dropped without a result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start the sequencer");

endmodule

### src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a page pool, one free bitmap per order in a RAM.
//
//   Channel  Handshake             Payload
//   in       start / busy          in_mode, in_order, in_address
//   out      out_valid (strobe)    out_status, out_block_address, out_free_bytes
//   cfg      cfg_we                cfg_wdata (pool base)
//
// One word at a time. Allocate scans bitmap words upward from the requested
// order, then splits one level per step; free visits one order per merge.
// Each scan or merge step reads the single-port bitmap RAM, whose read is
// registered, then checks the word. The result strobe is registered from
// the done state, and the next word may start while the strobe is high.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_ORDER     = 5,
  parameter int MIN_PAGE_LOG2 = 8,
  parameter int TOP_BLOCKS    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [2:0]        in_order,
  input  logic [31:0]       in_address,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [31:0]       out_block_address,
  output logic [FREE_W-1:0] out_free_bytes,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bpa_datapath #(
    .MAX_ORDER     (MAX_ORDER),
    .MIN_PAGE_LOG2 (MIN_PAGE_LOG2),
    .TOP_BLOCKS    (TOP_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_order          (in_order),
    .in_address        (in_address),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_free_bytes    (out_free_bytes)
  );

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == 32'd0)
    else $error("failed request returned a block address");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the buddy page allocator. A directed table of
// allocate and free words comes first, then about a thousand random words
// over several pool bases. Each result is checked against the table's value,
// if it gives one, else a bitmap model updated as each word is accepted.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP_ORDER  = 5;
  localparam int PAGE_SHIFT = 8;
  localparam int TOP_N      = 8;
  localparam int RAND_WORDS = 1000;
  localparam int CYCLE_CAP  = 600000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct {
    logic        mode;
    logic [2:0]  order;
    logic [31:0] addr;
    bit          typed;
    status_t     st;
    logic [31:0] baddr;
    logic [16:0] fbytes;
  } row_t;

  typedef struct {
    status_t     st;
    logic [31:0] baddr;
    logic [16:0] fbytes;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [2:0]  in_order;
  logic [31:0] in_address;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_block_address;
  logic [FREE_W-1:0] out_free_bytes;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  bit          free_bit [0:TOP_ORDER][0:255];
  logic [31:0] pool_base_m;
  alloc_result_t pending [$];
  logic [31:0] held_off [$];
  logic [2:0]  held_ord [$];
  int          errors;
  int          cycles;
  row_t        rows [$];

  buddy_page_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_order(in_order), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_block_address(out_block_address), .out_free_bytes(out_free_bytes),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int blocks_in(int k);
    return TOP_N << (TOP_ORDER - k);
  endfunction

  function automatic int lowest_free(int k);
    for (int i = 0; i < blocks_in(k); i++)
      if (free_bit[k][i]) return i;
    return blocks_in(k);
  endfunction

  function automatic logic [16:0] free_sum();
    int total;
    total = 0;
    for (int k = 0; k <= TOP_ORDER; k++)
      for (int i = 0; i < blocks_in(k); i++)
        if (free_bit[k][i]) total += 1 << (PAGE_SHIFT + k);
    return (total > FREE_LIMIT) ? 17'(FREE_LIMIT) : 17'(total);
  endfunction

  task automatic reset_pool();
    for (int k = 0; k <= TOP_ORDER; k++)
      for (int i = 0; i < 256; i++) free_bit[k][i] = 0;
    for (int i = 0; i < TOP_N; i++) free_bit[TOP_ORDER][i] = 1;
    pool_base_m = '0;
  endtask

  // Applies one word to the bitmap and returns the result it should cause.
  function automatic alloc_result_t apply_word(logic mode, logic [2:0] order,
                                               logic [31:0] addr);
    alloc_result_t r;
    int k;
    int idx;
    logic [31:0] offset;
    bit placed;
    r.st = ST_OK;
    r.baddr = '0;
    if (order > TOP_ORDER) begin
      r.st = ST_BAD_ORDER;
    end else if (mode == MODE_ALLOC) begin
      k = order;
      while (k <= TOP_ORDER && lowest_free(k) >= blocks_in(k)) k++;
      if (k > TOP_ORDER) begin
        r.st = ST_NO_BLOCK;
      end else begin
        for (; k > order; k--) begin
          idx = lowest_free(k);
          free_bit[k][idx] = 0;
          free_bit[k-1][2*idx] = 1;
          free_bit[k-1][2*idx+1] = 1;
        end
        idx = lowest_free(order);
        free_bit[order][idx] = 0;
        r.baddr = pool_base_m + (32'(idx) << (order + PAGE_SHIFT));
      end
    end else begin
      offset = addr - pool_base_m;
      k = order;
      if ((offset >> (k + PAGE_SHIFT)) < 32'(blocks_in(k))) begin
        placed = 0;
        for (; k < TOP_ORDER; k++) begin
          idx = int'(offset >> (k + PAGE_SHIFT));
          if (free_bit[k][idx ^ 1]) begin
            free_bit[k][idx ^ 1] = 0;
            offset &= ~((32'd1 << (k + 1 + PAGE_SHIFT)) - 1);
          end else begin
            free_bit[k][idx] = 1;
            placed = 1;
            break;
          end
        end
        if (!placed) free_bit[TOP_ORDER][int'(offset >> (TOP_ORDER + PAGE_SHIFT))] = 1;
      end
    end
    r.fbytes = free_sum();
    return r;
  endfunction

  task automatic write_base(logic [31:0] v);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_base_m = v;
  endtask

  // Drives one word and returns once it has been accepted.
  task automatic send(logic mode, logic [2:0] order, logic [31:0] addr, int idle_pct,
                      bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_order <= order;
    in_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_word(mode, order, addr);
    if (mode == MODE_ALLOC && r.st == ST_OK) begin
      held_off.push_back(r.baddr - pool_base_m);
      held_ord.push_back(order);
    end
    pending.push_back(typed ? typed_res : r);
  endtask

  task automatic add_row(logic mode, logic [2:0] order, logic [31:0] addr, bit typed,
                         status_t st, logic [16:0] fbytes);
    row_t w;
    w.mode = mode; w.order = order; w.addr = addr; w.typed = typed;
    w.st = st; w.baddr = '0; w.fbytes = fbytes;
    rows.push_back(w);
  endtask

  task automatic random_phase(int count, int idle_pct, bit drain_once);
    int pick;
    int sel;
    logic [2:0] ord;
    logic [31:0] a;
    alloc_result_t none;
    none = '{ST_OK, '0, '0};
    for (int n = 0; n < count; n++) begin
      if (drain_once && n == count / 2) begin
        start <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        // Noise: any order, any address, either operation.
        ord = 3'($urandom_range(7));
        a = $urandom();
        if ($urandom_range(1) == 1) a = pool_base_m + (a & 32'h0001_ffff);
        send(1'($urandom_range(1)), ord, a, idle_pct, 0, none);
      end else if (held_off.size() > 0 && (pick < 50 || held_off.size() > 40)) begin
        sel = $urandom_range(held_off.size() - 1);
        a = pool_base_m + held_off[sel];
        ord = held_ord[sel];
        held_off.delete(sel);
        held_ord.delete(sel);
        send(MODE_FREE, ord, a, idle_pct, 0, none);
      end else begin
        ord = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(TOP_ORDER));
        send(MODE_ALLOC, ord, $urandom(), idle_pct, 0, none);
      end
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h free=%0d", $realtime,
                 out_status, out_block_address, out_free_bytes);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d got %0d", $realtime, e.st, out_status);
          errors++;
        end
        if (out_block_address !== e.baddr) begin
          $display("%0t: block_address expected %h got %h", $realtime, e.baddr,
                   out_block_address);
          errors++;
        end
        if (out_free_bytes !== e.fbytes) begin
          $display("%0t: free_bytes expected %0d got %0d", $realtime, e.fbytes,
                   out_free_bytes);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    alloc_result_t t;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_ALLOC;
    in_order = '0;
    in_address = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    reset_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_base(32'h0000_0000);
    add_row(MODE_ALLOC, 3'd6, 32'h0, 1, ST_BAD_ORDER, 17'd65536);
    add_row(MODE_FREE, 3'd7, 32'h0, 1, ST_BAD_ORDER, 17'd65536);
    add_row(MODE_ALLOC, 3'd0, 32'h0, 1, ST_OK, 17'd65280);
    add_row(MODE_FREE, 3'd0, 32'h0, 1, ST_OK, 17'd65536);
    add_row(MODE_ALLOC, 3'd5, 32'h0, 1, ST_OK, 17'd57344);
    for (int i = 1; i < TOP_N; i++) add_row(MODE_ALLOC, 3'd5, 32'h0, 0, ST_OK, '0);
    // The pool is now fully taken.
    add_row(MODE_ALLOC, 3'd0, 32'h0, 1, ST_NO_BLOCK, 17'd0);
    add_row(MODE_FREE, 3'd5, 32'h0000_e000, 1, ST_OK, 17'd8192);
    add_row(MODE_FREE, 3'd0, 32'h0001_0000, 1, ST_OK, 17'd8192);
    add_row(MODE_FREE, 3'd5, 32'h0000_0123, 1, ST_OK, 17'd16384);
    add_row(MODE_FREE, 3'd5, 32'h0000_0000, 1, ST_OK, 17'd16384);
    add_row(MODE_FREE, 3'd0, 32'hffff_ffff, 1, ST_OK, 17'd16384);
    add_row(MODE_ALLOC, 3'd3, 32'hffff_ffff, 0, ST_OK, '0);
    add_row(MODE_ALLOC, 3'd7, 32'h0, 0, ST_OK, '0);
    add_row(MODE_FREE, 3'd3, 32'h0, 0, ST_OK, '0);
    add_row(MODE_FREE, 3'd1, 32'h0000_2200, 0, ST_OK, '0);
    foreach (rows[i]) begin
      t.st = rows[i].st;
      t.baddr = rows[i].baddr;
      t.fbytes = rows[i].fbytes;
      send(rows[i].mode, rows[i].order, rows[i].addr, 0, rows[i].typed, t);
    end

    random_phase(RAND_WORDS / 4, 0, 0);
    start <= 1'b0;
    write_base(32'hffff_ffff);
    random_phase(RAND_WORDS / 4, 45, 1);
    start <= 1'b0;
    write_base($urandom());
    random_phase(RAND_WORDS / 4, 0, 0);
    start <= 1'b0;
    write_base(32'hffff_8000);
    random_phase(RAND_WORDS / 4, 38, 0);
    start <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
